// ----- rtl/core/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants of the smoothed min/max normalizer
// Holds the request and response payload types, the controller to datapath
// command and status groups, and the fixed-point widths used everywhere.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int SMOOTH_BITS = SAMPLE_BITS + FRAC_BITS;
   localparam int DIFF_BITS   = SMOOTH_BITS + 1;
   localparam int ALPHA_BITS  = 16;
   localparam int PROD_BITS   = DIFF_BITS + ALPHA_BITS + 1;
   localparam int NORM_FRAC   = 14;
   localparam int NORM_BITS   = 16;
   localparam int QUOT_BITS   = NORM_FRAC + 2;
   localparam int STEP_BITS   = $clog2(QUOT_BITS);

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = ALPHA_BITS'(9830);
   localparam logic [NORM_BITS-1:0]  NORM_ONE    = NORM_BITS'(1 << NORM_FRAC);
   localparam logic [STEP_BITS-1:0]  STEP_LAST   = STEP_BITS'(QUOT_BITS - 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          reinit;
   } req_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0]   normalized;
      logic signed [SMOOTH_BITS-1:0] smoothed_out;
      logic                          degenerate;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic multiply;
      logic update;
      logic prepare;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ----- rtl/core/smm_ctrl.sv -----
// ----------------------------------------------------------------------------
// smm_ctrl: sequencing controller of the normalizer
// Walks one request through multiply, update, divide and output load, and
// owns the request ready and the response valid.
// ----------------------------------------------------------------------------
module smm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  smm_pkg::status_type status,
   output smm_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_UPD  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.prepare = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The result waits here until the output register is free.
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/core/smm_datapath.sv -----
// ----------------------------------------------------------------------------
// smm_datapath: arithmetic and state of the normalizer
// Holds alpha, the smoothed value and the tracked range, the smoothing
// multiplier, a restoring divider that yields one quotient bit per cycle,
// and the response register.
// ----------------------------------------------------------------------------
module smm_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [smm_pkg::ALPHA_BITS-1:0] csr_wr_data,
   input  smm_pkg::req_type    req_data,
   output smm_pkg::rsp_type    rsp_data,
   input  smm_pkg::cmd_type    cmd,
   output smm_pkg::status_type status
);

   localparam int SB = smm_pkg::SMOOTH_BITS;
   localparam int DB = smm_pkg::DIFF_BITS;
   localparam int PB = smm_pkg::PROD_BITS;
   localparam int QB = smm_pkg::QUOT_BITS;
   localparam int AB = smm_pkg::ALPHA_BITS;

   logic [AB-1:0]          alpha_ff;
   logic signed [SB-1:0]   x_ff;
   logic                   reinit_ff;
   logic signed [PB-1:0]   prod_ff;
   logic signed [SB-1:0]   smooth_ff, smooth_in;
   logic signed [SB-1:0]   low_ff, low_in;
   logic signed [SB-1:0]   high_ff, high_in;
   logic                   primed_ff;
   logic [DB-1:0]          rem_ff, rem_in;
   logic [SB-1:0]          den_ff;
   logic [QB-1:0]          quot_ff, quot_in;
   logic                   degen_ff;
   logic [smm_pkg::STEP_BITS-1:0] step_ff;
   smm_pkg::rsp_type       rsp_ff;

   logic signed [DB-1:0]   diff;
   logic signed [PB-1:0]   prod;
   logic signed [PB-1:0]   step_val;
   logic signed [DB-1:0]   sum;
   logic                   rem_ge;
   logic [DB-1:0]          rem_sub;
   logic [DB-1:0]          rem_keep;

   // Smoothing product: (x - smoothed) * alpha, alpha taken as a positive value.
   assign diff = DB'(x_ff) - DB'(smooth_ff);
   assign prod = PB'(diff) * $signed({1'b0, alpha_ff});

   // Arithmetic shift rounds toward minus infinity; the sum stays in range.
   assign step_val = prod_ff >>> AB;
   assign sum      = DB'(smooth_ff) + step_val[DB-1:0];

   always_comb begin
      smooth_in = smooth_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      if (reinit_ff || !primed_ff) begin
         smooth_in = x_ff;
         low_in    = x_ff;
         high_in   = x_ff;
      end else begin
         smooth_in = sum[SB-1:0];
         if (smooth_in < low_ff) begin
            low_in = smooth_in;
         end
         if (smooth_in > high_ff) begin
            high_in = smooth_in;
         end
      end
   end

   // One restoring step: compare, set the quotient bit, then double the remainder.
   assign rem_ge   = rem_ff >= {1'b0, den_ff};
   assign rem_sub  = rem_ff - {1'b0, den_ff};
   assign rem_keep = rem_ge ? rem_sub : rem_ff;
   assign rem_in   = {rem_keep[DB-2:0], 1'b0};
   assign quot_in  = {quot_ff[QB-2:0], rem_ge};

   assign status.div_last = (step_ff == smm_pkg::STEP_LAST);
   assign rsp_data        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= smm_pkg::ALPHA_RESET;
         smooth_ff <= '0;
         low_ff    <= '0;
         high_ff   <= '0;
         primed_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            alpha_ff <= csr_wr_data;
         end
         if (cmd.update) begin
            smooth_ff <= smooth_in;
            low_ff    <= low_in;
            high_ff   <= high_in;
            primed_ff <= 1'b1;
         end
         if (cmd.prepare) begin
            step_ff <= '0;
         end else if (cmd.div_step) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff      <= SB'(req_data.sample) <<< smm_pkg::FRAC_BITS;
         reinit_ff <= req_data.reinit;
      end
      if (cmd.multiply) begin
         prod_ff <= prod;
      end
      if (cmd.prepare) begin
         rem_ff   <= {1'b0, smooth_ff - low_ff};
         den_ff   <= high_ff - low_ff;
         degen_ff <= (high_ff == low_ff);
         quot_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
      if (cmd.load_out) begin
         rsp_ff.normalized   <= degen_ff ? '0 : $signed(quot_ff - smm_pkg::NORM_ONE);
         rsp_ff.smoothed_out <= smooth_ff;
         rsp_ff.degenerate   <= degen_ff;
      end
   end

endmodule

// ----- rtl/core/smoothed_minmax_normalizer.sv -----
// ----------------------------------------------------------------------------
// smoothed_minmax_normalizer: smoothed sensor value normalized to its range
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Each accepted request carries a signed 16-bit sample and a reinit flag and
// produces exactly one response. The first request after reset, or one with
// reinit set, loads the smoothed value, minimum and maximum with the sample
// (scaled to Q16.8); later requests move the smoothed value toward the sample
// by alpha (Q0.16, written through the csr port, reset 9830) and widen the
// tracked range. The response gives the smoothed value in Q16.8 and its
// position in the range as (smoothed - min) / (max - min) * 2 - 1 in Q1.14;
// when max equals min the position reads 0 and degenerate is set. After the
// request is accepted the block steps through multiply, update, divider
// setup, the bit-serial restoring divider and the output load, which waits
// until the output register is free. A request is taken only while the
// block is idle, so a new request waits until the previous one is loaded;
// a finished response sits in the output register, so the next request is
// accepted while the previous response still waits for rsp_ready. Alpha
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
module smoothed_minmax_normalizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  smm_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output smm_pkg::rsp_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic [smm_pkg::ALPHA_BITS-1:0] csr_wr_data
);

   // Commands from the controller and status back from the datapath.
   smm_pkg::cmd_type    cmd;
   smm_pkg::status_type status;

   smm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
